[design/pfa_pkg.sv]
package pfa_pkg;

    localparam int ADDR_W        = 40;
    localparam int CPU_IN_W      = 3;
    localparam int PAGE_BYTES    = 4096;
    localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
    localparam int PG_W          = ADDR_W - PAGE_SHIFT;
    localparam int NUM_CPUS_DEF  = 8;
    localparam int MAX_PAGES_DEF = 32768;
    localparam int CFG_IDX_W     = 2;

    localparam longint unsigned START_RST_L = 64'd2147483648;
    localparam longint unsigned STOP_RST_L  = 64'd2281701376;

    localparam logic [ADDR_W-1:0] REGION_START_RST = ADDR_W'(START_RST_L);
    localparam logic [ADDR_W-1:0] REGION_STOP_RST  = ADDR_W'(STOP_RST_L);
    // first managed page: start rounded up to a page multiple
    localparam logic [ADDR_W-1:0] REGION_BASE_RST  =
        ADDR_W'(((START_RST_L + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES);

    typedef enum logic {
        OP_ALLOC,
        OP_FREE
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_MEM   = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REGION_START = 2'd0,
        REG_REGION_STOP  = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK
    } state_t;

endpackage

[design/pfa_req_if.sv]
interface pfa_req_if
    import pfa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                op;
    logic [CPU_IN_W-1:0] cpu;
    logic [ADDR_W-1:0]   page_addr;

    modport source (output valid, output op, output cpu, output page_addr, input ready);
    modport sink   (input valid, input op, input cpu, input page_addr, output ready);
endinterface

[design/pfa_rsp_if.sv]
interface pfa_rsp_if
    import pfa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] granted_addr;
    logic [1:0]        status;

    modport source (output valid, output granted_addr, output status, input ready);
    modport sink   (input valid, input granted_addr, input status, output ready);
endinterface

[design/pfa_ram.sv]
// Simple dual-port RAM, one write and one registered read port
module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/pfa_rr_pick.sv]
// Round-robin first non-empty list, starting at (and including) first_idx
module pfa_rr_pick #(
    parameter int N = 8,
    parameter int W = 3
) (
    input  logic [N-1:0] busy,
    input  logic [W-1:0] first_idx,
    output logic         found,
    output logic [W-1:0] pick
);

    logic [2*N-1:0] rot;
    logic [W-1:0]   offs;
    logic [W:0]     sum;

    assign rot = {busy, busy} >> first_idx;

    always_comb
    begin
        offs = '0;
        for (int k = N - 1; k >= 0; k--)
        begin
            if (rot[k])
            begin
                offs = W'(k);
            end
        end
    end

    always_comb
    begin
        sum = {1'b0, first_idx} + {1'b0, offs};
        if (sum >= (W+1)'(N))
        begin
            sum = sum - (W+1)'(N);
        end
    end

    assign found = |busy;
    assign pick  = sum[W-1:0];

endmodule

[design/pfa_addr_chk.sv]
// Free address check and page index relative to the region base
module pfa_addr_chk
    import pfa_pkg::*;
#(
    parameter int MAX_PAGES = MAX_PAGES_DEF,
    parameter int IDX_W     = $clog2(MAX_PAGES_DEF)
) (
    input  logic [ADDR_W-1:0] addr,
    input  logic [ADDR_W-1:0] start,
    input  logic [ADDR_W-1:0] stop,
    input  logic [ADDR_W-1:0] base,
    output logic              ok,
    output logic [IDX_W-1:0]  idx
);

    logic [ADDR_W-1:0] diff;
    logic [PG_W-1:0]   page;
    logic              aligned;

    assign aligned = (addr[PAGE_SHIFT-1:0] == '0);
    assign diff    = addr - base;
    assign page    = diff[ADDR_W-1:PAGE_SHIFT];

    // aligned and >= start implies >= base, so diff does not wrap
    assign ok  = aligned && (addr >= start) && (addr < stop) && (page < PG_W'(MAX_PAGES));
    assign idx = page[IDX_W-1:0];

endmodule

[design/per_cpu_page_free_list_allocator_core.sv]
// Per-CPU LIFO page allocator. Each request on req gives exactly one transfer on rsp.
// A free (op=1) checks page_addr for alignment, for region_start <= addr < region_stop and
// for a page index below MAX_PAGES, then pushes the page onto the list of CPU cpu (reduced
// modulo NUM_CPUS); a bad address gives status 2 and changes nothing. An allocate (op=0) pops
// the requester's list head, or failing that steals the head of the first non-empty list
// going round from the next CPU; with every list empty it returns address 0 and status 1.
// Fill the region after reset by freeing every page. Double frees are not caught.
// Sequencing: a request is taken only when the sequencer is idle, so the next request is
// not taken before the sequencer has finished the last one. A free loads the result
// register in EXEC. An allocate issues the next-link RAM read in EXEC and loads the
// result register from the read data in LINK. Both then return to idle. The result
// register lets the next request be taken while a result still waits on rsp; that request
// then holds in the sequencer until the waiting result is taken. No clearing pass is
// needed after reset: list heads sit in flops cleared by reset, and link entries are always
// written by a push before being read.
// Configuration writes must only be issued while the block is idle.
module per_cpu_page_free_list_allocator_core
    import pfa_pkg::*;
#(
    parameter int NUM_CPUS  = NUM_CPUS_DEF,
    parameter int MAX_PAGES = MAX_PAGES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    pfa_req_if.sink              req,
    pfa_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int HEAD_W = $clog2(MAX_PAGES + 1);   // page index + 1, 0 = empty
    localparam int IDX_W  = $clog2(MAX_PAGES);

    // ---- registers ----
    state_t            state_reg, state_next;
    op_t               op_reg;
    logic [CPU_W-1:0]  cpu_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] stop_reg;
    logic [ADDR_W-1:0] base_reg;
    logic [HEAD_W-1:0] head_reg [NUM_CPUS];
    logic [CPU_W-1:0]  tgt_reg;        // list being popped
    logic [IDX_W-1:0]  pop_idx_reg;    // page being handed out
    logic              out_valid_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    status_t           out_status_reg;

    // ---- combinational ----
    logic [CPU_W-1:0]  cpu_mod;
    logic [ADDR_W-1:0] base_sum;
    logic [NUM_CPUS-1:0] busy;
    logic              pick_found;
    logic [CPU_W-1:0]  pick_idx;
    logic [HEAD_W-1:0] head_sel;
    logic [HEAD_W-1:0] head_m1;
    logic              chk_ok;
    logic [IDX_W-1:0]  free_idx;
    logic              slot_free;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [HEAD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [HEAD_W-1:0] ram_rdata;

    logic              head_we;
    logic [CPU_W-1:0]  head_widx;
    logic [HEAD_W-1:0] head_wdata;
    logic              pop_load;
    logic              out_load;
    logic [ADDR_W-1:0] out_addr_new;
    status_t           out_status_new;

    // cpu field reduced modulo NUM_CPUS (3-bit value, eight conditional compare-subtracts)
    always_comb
    begin
        logic [CPU_IN_W-1:0] r;
        r = req.cpu;
        for (int k = 0; k < (1 << CPU_IN_W); k++)
        begin
            if (int'(r) >= NUM_CPUS)
            begin
                r = r - CPU_IN_W'(NUM_CPUS);
            end
        end
        cpu_mod = CPU_W'(r);
    end

    // base = region_start rounded up to a page, kept alongside start
    assign base_sum = cfg_data + ADDR_W'(PAGE_BYTES - 1);

    always_comb
    begin
        for (int i = 0; i < NUM_CPUS; i++)
        begin
            busy[i] = (head_reg[i] != '0);
        end
    end

    pfa_rr_pick #(
        .N (NUM_CPUS),
        .W (CPU_W)
    ) u_pick (
        .busy      (busy),
        .first_idx (cpu_reg),
        .found     (pick_found),
        .pick      (pick_idx)
    );

    pfa_addr_chk #(
        .MAX_PAGES (MAX_PAGES),
        .IDX_W     (IDX_W)
    ) u_chk (
        .addr  (addr_reg),
        .start (start_reg),
        .stop  (stop_reg),
        .base  (base_reg),
        .ok    (chk_ok),
        .idx   (free_idx)
    );

    // next-link store: entry i holds the head value below page i
    pfa_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (MAX_PAGES)
    ) u_link (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign head_sel  = head_reg[pick_idx];
    assign head_m1   = head_sel - HEAD_W'(1);
    assign slot_free = !out_valid_reg || rsp.ready;

    // ---- sequencer: next state ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_ALLOC && pick_found)
                begin
                    state_next = S_LINK;
                end
                else if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_LINK:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---- sequencer: outputs ----
    always_comb
    begin
        ram_we         = 1'b0;
        ram_waddr      = free_idx;
        ram_wdata      = head_reg[cpu_reg];
        ram_re         = 1'b0;
        ram_raddr      = head_m1[IDX_W-1:0];
        head_we        = 1'b0;
        head_widx      = cpu_reg;
        head_wdata     = HEAD_W'(free_idx) + HEAD_W'(1);
        pop_load       = 1'b0;
        out_load       = 1'b0;
        out_addr_new   = '0;
        out_status_new = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
            end
            S_EXEC:
            begin
                if (op_reg == OP_FREE)
                begin
                    // push: link <- old head, head <- this page
                    out_load       = slot_free;
                    out_status_new = chk_ok ? ST_OK : ST_BAD_FREE;
                    ram_we         = slot_free && chk_ok;
                    head_we        = slot_free && chk_ok;
                end
                else if (pick_found)
                begin
                    ram_re   = 1'b1;
                    pop_load = 1'b1;
                end
                else
                begin
                    out_load       = slot_free;
                    out_status_new = ST_NO_MEM;
                end
            end
            S_LINK:
            begin
                // link data back: head <- next, hand out the page
                out_load     = slot_free;
                head_we      = slot_free;
                head_widx    = tgt_reg;
                head_wdata   = ram_rdata;
                out_addr_new = base_reg + (ADDR_W'(pop_idx_reg) << PAGE_SHIFT);
            end
            default:
            begin
            end
        endcase
    end

    assign req.ready = (state_reg == S_IDLE);

    // ---- control registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else if (head_we)
        begin
            head_reg[head_widx] <= head_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= REGION_START_RST;
            stop_reg  <= REGION_STOP_RST;
            base_reg  <= REGION_BASE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REGION_START:
                begin
                    start_reg <= cfg_data;
                    base_reg  <= {base_sum[ADDR_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
                end
                REG_REGION_STOP:
                begin
                    stop_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg   <= op_t'(req.op);
            cpu_reg  <= cpu_mod;
            addr_reg <= req.page_addr;
        end
        if (pop_load)
        begin
            tgt_reg     <= pick_idx;
            pop_idx_reg <= head_m1[IDX_W-1:0];
        end
        if (out_load)
        begin
            out_addr_reg   <= out_addr_new;
            out_status_reg <= out_status_new;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.granted_addr = out_addr_reg;
    assign rsp.status       = out_status_reg;

    // ---- checks ----
    a_nomem_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_NO_MEM) |-> (rsp.granted_addr == '0))
        else $error("out-of-memory result carries a non-zero address");

    a_nomem_all_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && op_reg == OP_ALLOC && !pick_found) |-> (busy == '0))
        else $error("out-of-memory reported with a list still holding pages");

    a_alloc_link: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && op_reg == OP_ALLOC && pick_found) |=> (state_reg == S_LINK))
        else $error("pop did not go on to the link read");

    a_free_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && op_reg == OP_FREE && chk_ok && slot_free)
        |=> (busy[$past(cpu_reg)]))
        else $error("list empty right after a good free");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");

endmodule
